// ===== rtl/lrupr_pkg.sv =====
// Package for the age-counter LRU page replacement block.
// Holds the fixed field widths, parameter defaults and queue sizing.
// No dependencies; imported by every module of the block but lrupr_ram.
`default_nettype none

package lrupr_pkg;

    // Defaults for the top-level parameters.
    localparam int FRAMES_DEF    = 16;
    localparam int PAGE_BITS_DEF = 16;
    localparam int AGE_BITS_DEF  = 16;

    // Fixed widths of the port fields.
    localparam int PAGE_W  = 16;
    localparam int IDX_W   = 4;
    localparam int CFG_W   = 5;
    localparam int COUNT_W = 32;

    // Value of the active frame register after reset.
    localparam logic [CFG_W-1:0] ACTIVE_RESET = CFG_W'(16);

    // Depth of the request queue between the front and the back end.
    localparam int QUEUE_DEPTH = 2;

endpackage

`default_nettype wire

// ===== rtl/lru_page_replacement.sv =====
// Top level of the age-counter LRU page replacement block.
// Instantiates lrupr_front and lrupr_back and holds the active frame register.
// Uses lrupr_pkg.
//
// Each request carries one page number and produces one result: hit or miss,
// the frame that now holds the page, the page evicted if any, and running hit
// and access counts. The frame table sits in a single-port-read RAM and is
// walked one frame per cycle in a read-modify-write scan that ages each
// filled frame; the back end then places the page on a miss and reports.
// A two-entry queue in front takes new requests while a result waits to be
// taken. The active frame register may be written at any time the block is
// idle; zero acts as one and values above FRAMES act as FRAMES.
`default_nettype none

module lru_page_replacement
    import lrupr_pkg::*;
#(
    parameter int FRAMES    = FRAMES_DEF,
    parameter int PAGE_BITS = PAGE_BITS_DEF,
    parameter int AGE_BITS  = AGE_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [PAGE_W-1:0]  i_page,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    output logic                    o_hit,
    output logic      [IDX_W-1:0]   o_frame_index,
    output logic                    o_evicted_valid,
    output logic      [PAGE_W-1:0]  o_evicted_page,
    output logic      [COUNT_W-1:0] o_hit_count,
    output logic      [COUNT_W-1:0] o_access_count,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    input  wire logic [CFG_W-1:0]   i_active_frames,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready
);

    localparam int CW = $clog2(FRAMES + 1);

    logic [CFG_W-1:0]     r_active;
    logic [31:0]          active_wide;
    logic [CW-1:0]        eff_frames;
    logic                 q_valid;
    logic                 q_pop;
    logic [PAGE_BITS-1:0] q_page;

    // Active frame register; writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= ACTIVE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_active <= i_active_frames;
        end
    end

    // Clamp the register to the range of built frames.
    always_comb begin
        active_wide = 32'(r_active);
        if (active_wide == '0) begin
            eff_frames = CW'(1);
        end else if (active_wide > 32'(FRAMES)) begin
            eff_frames = CW'(FRAMES);
        end else begin
            eff_frames = CW'(active_wide);
        end
    end

    lrupr_front #(
        .PAGE_BITS (PAGE_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_page     (i_page),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .o_q_valid  (q_valid),
        .i_q_pop    (q_pop),
        .o_q_page   (q_page)
    );

    lrupr_back #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS),
        .AGE_BITS  (AGE_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .o_q_pop         (q_pop),
        .i_q_page        (q_page),
        .i_eff_frames    (eff_frames),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_hit           (o_hit),
        .o_frame_index   (o_frame_index),
        .o_evicted_valid (o_evicted_valid),
        .o_evicted_page  (o_evicted_page),
        .o_hit_count     (o_hit_count),
        .o_access_count  (o_access_count)
    );

endmodule

`default_nettype wire

// ===== rtl/lrupr_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends only on its parameters; used for the frame table.
`default_nettype none

module lrupr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/lrupr_front.sv =====
// Front end: accepts page requests, trims them to the stored page width
// and holds them in a short queue for the back end. Uses lrupr_pkg.
`default_nettype none

module lrupr_front
    import lrupr_pkg::*;
#(
    parameter int PAGE_BITS = PAGE_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic [PAGE_W-1:0]    i_page,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    output logic                      o_q_valid,
    input  wire logic                 i_q_pop,
    output logic      [PAGE_BITS-1:0] o_q_page
);

    localparam int PW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

    logic [PAGE_BITS-1:0] r_slot [QUEUE_DEPTH];
    logic [PW-1:0]        r_wr, n_wr;
    logic [PW-1:0]        r_rd, n_rd;
    logic [CNTW-1:0]      r_count, n_count;
    logic                 push;
    logic                 pop;

    // Handshake on both sides of the queue.
    assign o_in_ready = (r_count != CNTW'(QUEUE_DEPTH));
    assign o_q_valid  = (r_count != '0);
    assign o_q_page   = r_slot[r_rd];
    assign push       = i_in_valid && o_in_ready;
    assign pop        = i_q_pop && o_q_valid;

    // Pointer and fill level update.
    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (push) begin
            n_wr = (r_wr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr + PW'(1);
        end
        if (pop) begin
            n_rd = (r_rd == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + PW'(1);
        end
        if (push && !pop) begin
            n_count = r_count + CNTW'(1);
        end else if (pop && !push) begin
            n_count = r_count - CNTW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // Queue storage; only the low page bits are kept.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr] <= PAGE_BITS'(i_page);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/lrupr_back.sv =====
// Back end: scans the filled frames for a match while ageing each of them,
// then on a miss fills or replaces a frame, and presents the result. Uses
// lrupr_pkg and lrupr_ram.
`default_nettype none

module lrupr_back
    import lrupr_pkg::*;
#(
    parameter int FRAMES    = FRAMES_DEF,
    parameter int PAGE_BITS = PAGE_BITS_DEF,
    parameter int AGE_BITS  = AGE_BITS_DEF,
    localparam int CW = $clog2(FRAMES + 1)
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_q_valid,
    output logic                      o_q_pop,
    input  wire logic [PAGE_BITS-1:0] i_q_page,
    input  wire logic [CW-1:0]        i_eff_frames,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic                      o_hit,
    output logic      [IDX_W-1:0]     o_frame_index,
    output logic                      o_evicted_valid,
    output logic      [PAGE_W-1:0]    o_evicted_page,
    output logic      [COUNT_W-1:0]   o_hit_count,
    output logic      [COUNT_W-1:0]   o_access_count
);

    localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int EW = PAGE_BITS + AGE_BITS;
    localparam logic [AGE_BITS-1:0] AGE_ONE = AGE_BITS'(1);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_DECIDE = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0]           r_state, n_state;
    logic [CW-1:0]        r_filled, n_filled;
    logic [PAGE_BITS-1:0] r_pg, n_pg;
    logic [CW-1:0]        r_raddr, n_raddr;
    logic                 r_dvalid, n_dvalid;
    logic [IW-1:0]        r_daddr, n_daddr;
    logic                 r_hit, n_hit;
    logic [IW-1:0]        r_where, n_where;
    logic                 r_evict, n_evict;
    logic [PAGE_BITS-1:0] r_ev_page, n_ev_page;
    logic [IW-1:0]        r_best, n_best;
    logic [AGE_BITS-1:0]  r_best_age, n_best_age;
    logic [PAGE_BITS-1:0] r_best_page, n_best_page;
    logic [COUNT_W-1:0]   r_hits, n_hits;
    logic [COUNT_W-1:0]   r_refs, n_refs;
    logic                 r_out_valid, n_out_valid;
    logic                 r_o_hit, n_o_hit;
    logic [IW-1:0]        r_o_where, n_o_where;
    logic                 r_o_evict, n_o_evict;
    logic [PAGE_BITS-1:0] r_o_ev_page, n_o_ev_page;

    logic                 ram_we;
    logic [IW-1:0]        ram_waddr;
    logic [EW-1:0]        ram_wdata;
    logic                 ram_re;
    logic [IW-1:0]        ram_raddr;
    logic [EW-1:0]        ram_rdata;

    logic [PAGE_BITS-1:0] d_page;
    logic [AGE_BITS-1:0]  d_age;
    logic [AGE_BITS-1:0]  d_aged;
    logic                 d_match;
    logic                 d_last;
    logic                 d_better;
    logic                 out_free;

    // Frame table: page number above, age counter below.
    lrupr_ram #(
        .WIDTH (EW),
        .DEPTH (FRAMES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Examine the frame that the table returned this cycle.
    assign d_page   = ram_rdata[EW-1:AGE_BITS];
    assign d_age    = ram_rdata[AGE_BITS-1:0];
    assign d_match  = (d_page == r_pg);
    assign d_aged   = d_match ? AGE_ONE :
                      ((d_age == '1) ? d_age : d_age + AGE_ONE);
    assign d_last   = (CW'(r_daddr) == r_filled - CW'(1));
    assign d_better = (r_daddr == '0) || (d_aged > r_best_age);
    assign out_free = !r_out_valid || i_out_ready;

    // Sequencer: fetch a request, scan and age, place the page, report.
    always_comb begin
        n_state     = r_state;
        n_filled    = r_filled;
        n_pg        = r_pg;
        n_raddr     = r_raddr;
        n_dvalid    = r_dvalid;
        n_daddr     = r_daddr;
        n_hit       = r_hit;
        n_where     = r_where;
        n_evict     = r_evict;
        n_ev_page   = r_ev_page;
        n_best      = r_best;
        n_best_age  = r_best_age;
        n_best_page = r_best_page;
        n_hits      = r_hits;
        n_refs      = r_refs;
        n_out_valid = r_out_valid;
        n_o_hit     = r_o_hit;
        n_o_where   = r_o_where;
        n_o_evict   = r_o_evict;
        n_o_ev_page = r_o_ev_page;
        ram_we      = 1'b0;
        ram_waddr   = r_daddr;
        ram_wdata   = {d_page, d_aged};
        ram_re      = 1'b0;
        ram_raddr   = r_raddr[IW-1:0];
        o_q_pop     = 1'b0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop   = 1'b1;
                    n_pg      = i_q_page;
                    n_hit     = 1'b0;
                    n_evict   = 1'b0;
                    n_ev_page = '0;
                    n_where   = '0;
                    if (r_filled == '0) begin
                        n_state = S_DECIDE;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = '0;
                        n_raddr   = CW'(1);
                        n_dvalid  = 1'b1;
                        n_daddr   = '0;
                        n_state   = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // Keep reading ahead while filled frames remain.
                if (r_raddr < r_filled) begin
                    ram_re   = 1'b1;
                    n_raddr  = r_raddr + CW'(1);
                    n_dvalid = 1'b1;
                    n_daddr  = r_raddr[IW-1:0];
                end else begin
                    n_dvalid = 1'b0;
                end
                // Write back the aged frame and track match and oldest.
                if (r_dvalid) begin
                    ram_we = 1'b1;
                    if (d_match) begin
                        n_hit   = 1'b1;
                        n_where = r_daddr;
                    end
                    if (d_better) begin
                        n_best      = r_daddr;
                        n_best_age  = d_aged;
                        n_best_page = d_page;
                    end
                    if (d_last) begin
                        n_state = S_DECIDE;
                    end
                end
            end
            S_DECIDE: begin
                // On a miss, fill the next empty frame or replace the oldest.
                if (!r_hit) begin
                    ram_we    = 1'b1;
                    ram_wdata = {r_pg, AGE_ONE};
                    if (r_filled < i_eff_frames) begin
                        ram_waddr = r_filled[IW-1:0];
                        n_where   = r_filled[IW-1:0];
                        n_filled  = r_filled + CW'(1);
                    end else begin
                        ram_waddr = r_best;
                        n_where   = r_best;
                        n_evict   = 1'b1;
                        n_ev_page = r_best_page;
                    end
                end
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_o_hit     = r_hit;
                    n_o_where   = r_where;
                    n_o_evict   = r_evict;
                    n_o_ev_page = r_ev_page;
                    n_hits      = r_hits + COUNT_W'(r_hit);
                    n_refs      = r_refs + COUNT_W'(1);
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state and counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_filled    <= '0;
            r_dvalid    <= 1'b0;
            r_hits      <= '0;
            r_refs      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_filled    <= n_filled;
            r_dvalid    <= n_dvalid;
            r_hits      <= n_hits;
            r_refs      <= n_refs;
            r_out_valid <= n_out_valid;
        end
    end

    // Working and result payload registers.
    always_ff @(posedge i_clk) begin
        r_pg        <= n_pg;
        r_raddr     <= n_raddr;
        r_daddr     <= n_daddr;
        r_hit       <= n_hit;
        r_where     <= n_where;
        r_evict     <= n_evict;
        r_ev_page   <= n_ev_page;
        r_best      <= n_best;
        r_best_age  <= n_best_age;
        r_best_page <= n_best_page;
        r_o_hit     <= n_o_hit;
        r_o_where   <= n_o_where;
        r_o_evict   <= n_o_evict;
        r_o_ev_page <= n_o_ev_page;
    end

    // The counters change only when a result is loaded, so they can drive
    // the output directly.
    assign o_out_valid     = r_out_valid;
    assign o_hit           = r_o_hit;
    assign o_frame_index   = IDX_W'(r_o_where);
    assign o_evicted_valid = r_o_evict;
    assign o_evicted_page  = PAGE_W'(r_o_ev_page);
    assign o_hit_count     = r_hits;
    assign o_access_count  = r_refs;

endmodule

`default_nettype wire

// ===== rtl/lrupr_chk.sv =====
// Port-level checker for lru_page_replacement, attached by a bind statement.
// Uses lrupr_pkg for the field widths.
`default_nettype none

module lrupr_chk
    import lrupr_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               o_out_valid,
    input wire logic               i_out_ready,
    input wire logic               o_hit,
    input wire logic [IDX_W-1:0]   o_frame_index,
    input wire logic               o_evicted_valid,
    input wire logic [PAGE_W-1:0]  o_evicted_page,
    input wire logic [COUNT_W-1:0] o_hit_count,
    input wire logic [COUNT_W-1:0] o_access_count
);

    // A stalled result keeps its hit flag, frame index, evicted page and access count.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_hit)
            && $stable(o_frame_index) && $stable(o_evicted_page)
            && $stable(o_access_count))
        else $error("result changed while stalled");

    // A hit never evicts anything.
    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_hit |-> !o_evicted_valid)
        else $error("hit reported an eviction");

    // With no eviction the evicted page reads as zero.
    a_evict_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_evicted_valid |-> o_evicted_page == '0)
        else $error("evicted page not zero without eviction");

    // Back-to-back results advance the counts by exactly one request.
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready |=> !o_out_valid
            || (o_access_count == $past(o_access_count) + COUNT_W'(1)
            && o_hit_count == $past(o_hit_count) + COUNT_W'(o_hit)))
        else $error("counts did not step by one request");

endmodule

bind lru_page_replacement lrupr_chk u_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_hit           (o_hit),
    .o_frame_index   (o_frame_index),
    .o_evicted_valid (o_evicted_valid),
    .o_evicted_page  (o_evicted_page),
    .o_hit_count     (o_hit_count),
    .o_access_count  (o_access_count)
);

`default_nettype wire
